@@ rtl/core/sss_pkg.sv @@
package sss_pkg;

	localparam int QBITS = 16;
	localparam int SCORE_W = 17;
	localparam int VALUE_W = 32;
	localparam int MATCH_W = 11;

	localparam logic [0:0] MODE_JACCARD = 1'b0;
	localparam logic [0:0] MODE_DICE = 1'b1;

	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_THRESH = 1'b1;

	localparam logic SIDE_SOURCE = 1'b0;
	localparam logic SIDE_TARGET = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RATIO,
		ST_MERGE,
		ST_DIVIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage

@@ rtl/core/sorted_set_similarity_core.sv @@
// Loads a source and a target sorted list, one item per cycle, into two
// MAX_ELEMS-deep RAMs; an item with s_tlast set ends the pair. The core then
// optionally forms the Jaccard size ratio (one divider pass), walks both RAMs
// in a merge, as each compare waits for the registered read, and divides once
// more for the Q1.16 score on the bit-serial divider. A result is emitted per
// pair; input is held off from pair end until the result register is free
// again. Stores need no clearing: lengths reset to zero.
module sorted_set_similarity_core #(
	parameter int MAX_ELEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] element_value
	input  logic [31:0] s_tdata,
	// [0] list_side
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [16:0] score, [27:17] match_count, [28] took_shortcut, [29] empty_error
	output logic [31:0] m_tdata
);

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int LW = $clog2(MAX_ELEMS + 1);
	localparam int SW = LW + 1;
	localparam int NW = SW + sss_pkg::QBITS + 1;
	localparam int VW = sss_pkg::VALUE_W;

	sss_pkg::state_t state_q, state_d;

	logic        mode_q;
	logic [16:0] thresh_q;
	logic [LW-1:0] slen_q, tlen_q;
	logic [LW-1:0] i_q, j_q;
	logic [LW-1:0] inter_q;
	logic          rd_valid_q;
	logic          ratio_phase_q;
	logic [sss_pkg::SCORE_W-1:0] score_q;
	logic [sss_pkg::MATCH_W-1:0] match_q;
	logic shortcut_q, err_q, out_valid_q;

	logic accept, src_we, tgt_we;
	logic [VW-1:0] src_rd, tgt_rd;
	logic [AW-1:0] src_ra, tgt_ra;
	logic [LW-1:0] s_fin, t_fin;
	logic merge_end;

	logic div_start;
	logic [NW-1:0] div_num, div_quot;
	logic [SW-1:0] div_den;
	sss_pkg::div_ctl_t div_ctl;

	logic [LW-1:0] lo, hi;
	logic [SW-1:0] sum_st;

	logic err_q_out, shortcut_out;
	logic [sss_pkg::SCORE_W-1:0] score_out;
	logic [sss_pkg::SCORE_W-1:0] score_hold_q;
	logic err_hold_q, sc_hold_q;

	assign accept = s_tvalid && s_tready;
	assign src_we = accept && (s_tuser == sss_pkg::SIDE_SOURCE) && (slen_q < LW'(MAX_ELEMS));
	assign tgt_we = accept && (s_tuser == sss_pkg::SIDE_TARGET) && (tlen_q < LW'(MAX_ELEMS));

	// lengths including the item that closes the pair
	assign s_fin = slen_q;
	assign t_fin = tlen_q;

	assign src_ra = i_q[AW-1:0];
	assign tgt_ra = j_q[AW-1:0];

	sss_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMS)) u_src (
		.clk(clk), .we(src_we), .waddr(slen_q[AW-1:0]), .wdata(s_tdata),
		.raddr(src_ra), .rdata(src_rd)
	);

	sss_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMS)) u_tgt (
		.clk(clk), .we(tgt_we), .waddr(tlen_q[AW-1:0]), .wdata(s_tdata),
		.raddr(tgt_ra), .rdata(tgt_rd)
	);

	assign lo = (s_fin <= t_fin) ? s_fin : t_fin;
	assign hi = (s_fin <= t_fin) ? t_fin : s_fin;
	assign sum_st = SW'(s_fin) + SW'(t_fin);

	assign merge_end = (i_q >= s_fin) || (j_q >= t_fin);

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		if (state_q == sss_pkg::ST_RATIO && !ratio_phase_q && hi != '0) begin
			div_start = 1'b1;
			div_num = NW'({lo, 16'b0});
			div_den = SW'(hi);
		end else if (state_q == sss_pkg::ST_MERGE && rd_valid_q && merge_end) begin
			div_start = (mode_q == sss_pkg::MODE_DICE) ? (sum_st != '0)
				: ((sum_st - SW'(inter_q)) != '0);
			if (mode_q == sss_pkg::MODE_DICE) begin
				div_num = NW'({inter_q, 17'b0});
				div_den = sum_st;
			end else begin
				div_num = NW'({inter_q, 16'b0});
				div_den = sum_st - SW'(inter_q);
			end
		end
	end

	sss_div #(.NW(NW), .DW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .ctl(div_ctl), .quot(div_quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sss_pkg::ST_LOAD: begin
				if (accept && s_tlast) begin
					state_d = (thresh_q != '0 && mode_q == sss_pkg::MODE_JACCARD)
						? sss_pkg::ST_RATIO : sss_pkg::ST_MERGE;
				end
			end
			sss_pkg::ST_RATIO: begin
				if (!ratio_phase_q) begin
					if (hi == '0) state_d = sss_pkg::ST_OUT;
				end else if (!div_ctl.busy) begin
					state_d = (div_quot < NW'(thresh_q)) ? sss_pkg::ST_OUT
						: sss_pkg::ST_MERGE;
				end
			end
			sss_pkg::ST_MERGE: begin
				if (rd_valid_q && merge_end) begin
					state_d = div_start ? sss_pkg::ST_DIVIDE : sss_pkg::ST_OUT;
				end
			end
			sss_pkg::ST_DIVIDE: begin
				if (!div_ctl.start && !div_ctl.busy) state_d = sss_pkg::ST_OUT;
			end
			sss_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) state_d = sss_pkg::ST_LOAD;
			end
			default: state_d = sss_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = (state_q == sss_pkg::ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sss_pkg::ST_LOAD;
			mode_q <= 1'b0;
			thresh_q <= '0;
			slen_q <= '0;
			tlen_q <= '0;
			i_q <= '0;
			j_q <= '0;
			inter_q <= '0;
			rd_valid_q <= 1'b0;
			ratio_phase_q <= 1'b0;
			out_valid_q <= 1'b0;
			shortcut_q <= 1'b0;
			err_q <= 1'b0;
			score_q <= '0;
			match_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					sss_pkg::REG_MODE: mode_q <= cfg_wdata[0];
					sss_pkg::REG_THRESH: thresh_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (src_we) slen_q <= slen_q + 1'b1;
			if (tgt_we) tlen_q <= tlen_q + 1'b1;
			if (out_valid_q && m_tready && state_q != sss_pkg::ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				sss_pkg::ST_LOAD: begin
					i_q <= '0;
					j_q <= '0;
					inter_q <= '0;
					rd_valid_q <= 1'b0;
					ratio_phase_q <= 1'b0;
					shortcut_q <= 1'b0;
					err_q <= 1'b0;
					score_q <= '0;
				end
				sss_pkg::ST_RATIO: begin
					if (!ratio_phase_q) begin
						ratio_phase_q <= 1'b1;
						if (hi == '0) err_q <= 1'b1;
					end else if (!div_ctl.busy && div_quot < NW'(thresh_q)) begin
						score_q <= div_quot[sss_pkg::SCORE_W-1:0];
						shortcut_q <= 1'b1;
					end
				end
				sss_pkg::ST_MERGE: begin
					// a compare is made only once read data is valid; address moves only after data returns
					if (!rd_valid_q) begin
						rd_valid_q <= 1'b1;
					end else if (merge_end) begin
						if (!div_start) err_q <= 1'b1;
					end else begin
						rd_valid_q <= 1'b0;
						if (src_rd < tgt_rd) begin
							i_q <= i_q + 1'b1;
						end else if (tgt_rd < src_rd) begin
							j_q <= j_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= j_q + 1'b1;
							inter_q <= inter_q + 1'b1;
						end
					end
				end
				sss_pkg::ST_DIVIDE: begin
					if (!div_ctl.start && !div_ctl.busy) begin
						score_q <= div_quot[sss_pkg::SCORE_W-1:0];
					end
				end
				sss_pkg::ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						match_q <= shortcut_q ? '0 : sss_pkg::MATCH_W'(inter_q);
						slen_q <= '0;
						tlen_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, err_q_out, shortcut_out, match_q, score_out};

	always_ff @(posedge clk) begin
		if (state_q == sss_pkg::ST_OUT && (!out_valid_q || m_tready)) begin
			score_hold_q <= score_q;
			err_hold_q <= err_q;
			sc_hold_q <= shortcut_q;
		end
	end

	assign score_out = score_hold_q;
	assign err_q_out = err_hold_q;
	assign shortcut_out = sc_hold_q;

endmodule

@@ rtl/core/sss_ram.sv @@
module sss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/sss_div.sv @@
// restoring divider, one quotient bit per cycle
module sss_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   num,
	input  logic [DW-1:0]   den,
	output sss_pkg::div_ctl_t ctl,
	output logic [NW-1:0]   quot
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quot_q;
	logic [DW:0]   trial;

	assign trial = {rem_q[DW-1:0], quot_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quot_q <= num;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, busy: (cnt_q != '0)};
	assign quot = quot_q;

endmodule

@@ rtl/core/sss_checker.sv @@
module sss_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[16:0] == 17'd0)
		else $error("error result with nonzero score");

	a_sc_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28] |-> m_tdata[27:17] == 11'd0 && !m_tdata[29])
		else $error("shortcut result with matches or error");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after pair end");

endmodule

bind sorted_set_similarity_core sss_props u_sss_props (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
